// File: src/merge_sort_engine_defines.svh
// Assertion macros for the merge sort engine.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// same-cycle implication
`define MSORT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSORT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/msort_pkg.sv
// Shared types and defaults for the merge sort engine.
// No dependencies; used by msort_core and merge_sort_engine.
package msort_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEG,
    ST_LDA,
    ST_LDB,
    ST_MERGE,
    ST_FILLA,
    ST_FILLB,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_HOLD
  } state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd_b;
  } mem_ctl_t;

endpackage

// File: src/msort_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/msort_core.sv
// Load, bottom-up merge and emit sequencer of the merge sort engine.
// Depends on msort_pkg; drives two msort_ram instances through the top level.
module msort_core #(
  parameter int DEPTH      = msort_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = msort_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_sorted_value,
  output logic                         out_final_res,
  output logic                         out_overflow,
  output msort_pkg::mem_ctl_t          mem_ctl,
  output logic [$clog2(DEPTH)-1:0]     wr_addr,
  output logic [DATA_WIDTH-1:0]        wr_data,
  output logic [$clog2(DEPTH)-1:0]     rd_addr,
  input  logic [DATA_WIDTH-1:0]        rd_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = CW + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  msort_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW:0]   width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          src_b_r, src_b_nxt;
  logic signed [DATA_WIDTH-1:0] head_a_r, head_a_nxt;
  logic signed [DATA_WIDTH-1:0] head_b_r, head_b_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic          out_final_r, out_final_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          in_fire, out_fire, full, multi;
  logic [CW-1:0] count_inc, n_after, k_inc;
  logic [SW-1:0] sum_mid, sum_hi, n_s;
  logic [CW-1:0] mid_c, hi_c;
  logic [CW:0]   i_inc, j_inc, width_dbl;
  logic          a_ok, b_ok, take_a, take_b, i_more, j_more, pass_end, seg_last;

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign full      = count_r >= DEPTH_C;
  assign count_inc = count_r + ONE_C;
  assign n_after   = full ? count_r : count_inc;
  assign multi     = n_after > ONE_C;
  assign k_inc     = k_r + ONE_C;

  assign n_s     = {2'b00, count_r};
  assign sum_mid = {2'b00, lo_r} + {1'b0, width_r};
  assign sum_hi  = {2'b00, lo_r} + {width_r, 1'b0};
  assign mid_c   = (sum_mid < n_s) ? sum_mid[CW-1:0] : count_r;
  assign hi_c    = (sum_hi < n_s) ? sum_hi[CW-1:0] : count_r;

  assign a_ok     = i_r < mid_r;
  assign b_ok     = j_r < hi_r;
  assign take_a   = a_ok && (!b_ok || (head_a_r <= head_b_r));
  assign take_b   = b_ok && !take_a;
  assign i_inc    = {1'b0, i_r} + {{CW{1'b0}}, 1'b1};
  assign j_inc    = {1'b0, j_r} + {{CW{1'b0}}, 1'b1};
  assign i_more   = i_inc < {1'b0, mid_r};
  assign j_more   = j_inc < {1'b0, hi_r};
  assign seg_last = hi_r == count_r;
  assign width_dbl = {width_r[CW-1:0], 1'b0};
  assign pass_end  = width_dbl >= {1'b0, count_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msort_pkg::ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = multi ? msort_pkg::ST_SEG : msort_pkg::ST_OUT_RD;
        end
      end
      msort_pkg::ST_SEG: state_nxt = msort_pkg::ST_LDA;
      msort_pkg::ST_LDA: begin
        state_nxt = b_ok ? msort_pkg::ST_LDB : msort_pkg::ST_MERGE;
      end
      msort_pkg::ST_LDB,
      msort_pkg::ST_FILLA,
      msort_pkg::ST_FILLB: state_nxt = msort_pkg::ST_MERGE;
      msort_pkg::ST_MERGE: begin
        if (take_a) begin
          state_nxt = i_more ? msort_pkg::ST_FILLA : msort_pkg::ST_MERGE;
        end else if (take_b) begin
          state_nxt = j_more ? msort_pkg::ST_FILLB : msort_pkg::ST_MERGE;
        end else if (!seg_last || !pass_end) begin
          state_nxt = msort_pkg::ST_SEG;
        end else begin
          state_nxt = msort_pkg::ST_OUT_RD;
        end
      end
      msort_pkg::ST_OUT_RD: state_nxt = msort_pkg::ST_OUT_WAIT;
      msort_pkg::ST_OUT_WAIT: state_nxt = msort_pkg::ST_OUT_HOLD;
      msort_pkg::ST_OUT_HOLD: begin
        if (out_fire) begin
          state_nxt = out_final_r ? msort_pkg::ST_LOAD : msort_pkg::ST_OUT_WAIT;
        end
      end
      default: state_nxt = msort_pkg::ST_LOAD;
    endcase
  end

  // memory port outputs
  always_comb begin
    mem_ctl      = '0;
    mem_ctl.rd_b = src_b_r;
    wr_addr      = count_r[AW-1:0];
    wr_data      = in_value;
    rd_addr      = k_r[AW-1:0];
    case (state_r)
      msort_pkg::ST_LOAD: begin
        mem_ctl.wr_a = in_fire && !full;
      end
      msort_pkg::ST_SEG: begin
        rd_addr = lo_r[AW-1:0];
      end
      msort_pkg::ST_LDA: begin
        rd_addr = j_r[AW-1:0];
      end
      msort_pkg::ST_MERGE: begin
        wr_addr = k_r[AW-1:0];
        if (take_a) begin
          mem_ctl.wr_a = src_b_r;
          mem_ctl.wr_b = !src_b_r;
          wr_data      = head_a_r;
          rd_addr      = i_inc[AW-1:0];
        end else if (take_b) begin
          mem_ctl.wr_a = src_b_r;
          mem_ctl.wr_b = !src_b_r;
          wr_data      = head_b_r;
          rd_addr      = j_inc[AW-1:0];
        end
      end
      msort_pkg::ST_OUT_HOLD: begin
        rd_addr = k_inc[AW-1:0];
      end
      default: begin
        rd_addr = k_r[AW-1:0];
      end
    endcase
  end

  // datapath updates
  always_comb begin
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    src_b_nxt     = src_b_r;
    head_a_nxt    = head_a_r;
    head_b_nxt    = head_b_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      msort_pkg::ST_LOAD: begin
        if (in_fire) begin
          count_nxt = n_after;
          drop_nxt  = drop_r || full;
          if (in_last) begin
            width_nxt = {{CW{1'b0}}, 1'b1};
            lo_nxt    = '0;
            k_nxt     = '0;
            src_b_nxt = 1'b0;
          end
        end
      end
      msort_pkg::ST_SEG: begin
        mid_nxt = mid_c;
        hi_nxt  = hi_c;
        i_nxt   = lo_r;
        j_nxt   = mid_c;
        k_nxt   = lo_r;
      end
      msort_pkg::ST_LDA,
      msort_pkg::ST_FILLA: head_a_nxt = rd_data;
      msort_pkg::ST_LDB,
      msort_pkg::ST_FILLB: head_b_nxt = rd_data;
      msort_pkg::ST_MERGE: begin
        if (take_a) begin
          i_nxt = i_inc[CW-1:0];
          k_nxt = k_inc;
        end else if (take_b) begin
          j_nxt = j_inc[CW-1:0];
          k_nxt = k_inc;
        end else if (!seg_last) begin
          lo_nxt = hi_r;
        end else begin
          width_nxt = width_dbl;
          src_b_nxt = !src_b_r;
          lo_nxt    = '0;
          k_nxt     = '0;
        end
      end
      msort_pkg::ST_OUT_WAIT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data;
        out_final_nxt = k_inc == count_r;
        out_ovf_nxt   = drop_r;
      end
      msort_pkg::ST_OUT_HOLD: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_inc;
          if (out_final_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msort_pkg::ST_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    width_r     <= width_nxt;
    lo_r        <= lo_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    src_b_r     <= src_b_nxt;
    head_a_r    <= head_a_nxt;
    head_b_r    <= head_b_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_stall         = state_r != msort_pkg::ST_LOAD;
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_final_res    = out_final_r;
  assign out_overflow     = out_ovf_r;

endmodule

// File: src/merge_sort_engine.sv
// Merge sort engine: loads a framed sequence of signed words into RAM A, sorts it
// ascending with a stable bottom-up merge that ping-pongs between RAM A and RAM B,
// then emits the sorted words with the last one flagged. Words past DEPTH are
// dropped and every result of that sequence carries overflow. Loading accepts one
// word per cycle. For n stored words the sort runs ceil(log2 n) passes; in each pass
// a taken head is refilled by a fresh read from the registered read port of the
// source RAM. Emitting is paced by that read port as well. No clearing pass follows
// reset; in_stall is high from the last word until the last result is taken.
// Depends on msort_pkg, msort_ram, msort_core and merge_sort_engine_defines.svh.
`include "merge_sort_engine_defines.svh"

module merge_sort_engine #(
  parameter int DEPTH      = msort_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = msort_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_sorted_value,
  output logic                         out_final_res,
  output logic                         out_overflow
);

  localparam int AW = $clog2(DEPTH);

  msort_pkg::mem_ctl_t   mem_ctl;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data, rd_data_a, rd_data_b;
  logic                  rd_sel_r;

  msort_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .we      (mem_ctl.wr_a),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data_a)
  );

  msort_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .we      (mem_ctl.wr_b),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data_b)
  );

  // align the source select with the registered read data
  always_ff @(posedge clk) begin
    rd_sel_r <= mem_ctl.rd_b;
  end

  assign rd_data = rd_sel_r ? rd_data_b : rd_data_a;

  msort_core #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow),
    .mem_ctl          (mem_ctl),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data)
  );

  `MSORT_ASSERT_NOW(a_no_emit_while_loading, !in_stall, !out_valid, "result shown during load")
  `MSORT_ASSERT_NOW(a_one_ram_written, 1'b1, !(mem_ctl.wr_a && mem_ctl.wr_b), "both RAMs written")
  `MSORT_ASSERT_NEXT(a_last_closes_load, in_valid && !in_stall && in_last, in_stall, "load not closed")
  `MSORT_ASSERT_NEXT(a_final_reopens, out_valid && !out_stall && out_final_res, !in_stall && !out_valid, "load not reopened")

endmodule

// File: dv/tb_merge_sort_engine.sv
// Self-checking testbench for merge_sort_engine: framed words in, sorted words out.
// Directed sequences from a table, then random framed sequences, all scored against
// an in-bench sort predictor. Depends on msort_pkg and the merge_sort_engine RTL.
module tb_merge_sort_engine;

  localparam int DW       = msort_pkg::DATA_WIDTH_DEF;
  localparam int DEPTH    = msort_pkg::DEPTH_DEF;
  localparam int LIMIT    = 20000;
  localparam int HOLD_LEN = 400;
  localparam int RAND_WORDS = 170;
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] VMAX = ~VMIN;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 is_final;
    logic                 ovf;
  } sorted_word_t;

  typedef struct packed {
    logic signed [DW-1:0] first;
    logic signed [DW-1:0] step;
    int                   count;
    bit                   typed;
    logic signed [DW-1:0] exp_val;
  } seq_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [DW-1:0] in_value = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_sorted_value;
  logic                 out_final_res;
  logic                 out_overflow;

  bit                   word_typed = 1'b0;
  logic signed [DW-1:0] word_exp = '0;

  logic signed [DW-1:0] held_words [DEPTH];
  int                   held_count = 0;
  bit                   held_lost = 1'b0;
  sorted_word_t         sorted_q [$];

  int errors = 0;
  int idle_cycles = 0;
  int words_sent = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;

  seq_row_t seq_rows [10] = '{
    '{32'sd0,  32'sd0,  1,  1'b1, 32'sd0},
    '{VMIN,    32'sd0,  1,  1'b1, VMIN},
    '{VMAX,    32'sd0,  1,  1'b1, VMAX},
    '{-32'sd1, 32'sd0,  1,  1'b1, -32'sd1},
    '{VMAX,    32'sd1,  2,  1'b0, 32'sd0},
    '{32'sd100, -32'sd7, 8, 1'b0, 32'sd0},
    '{32'sd5,  32'sd0,  6,  1'b0, 32'sd0},
    '{-32'sd9, 32'sd2,  DEPTH + 1, 1'b0, 32'sd0},
    '{32'sd7,  32'sd0,  1,  1'b1, 32'sd7},
    '{-32'sd3, 32'sd1,  7,  1'b0, 32'sd0}
  };

  merge_sort_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  always #2 clk = ~clk;

  task automatic absorb_word(input logic signed [DW-1:0] v, input logic l);
    logic signed [DW-1:0] key;
    int j;
    sorted_word_t w;
    if (held_count < DEPTH) begin
      held_words[held_count] = v;
      held_count++;
    end else begin
      held_lost = 1'b1;
    end
    if (l) begin
      for (int i = 1; i < held_count; i++) begin
        key = held_words[i];
        j = i - 1;
        while (j >= 0 && held_words[j] > key) begin
          held_words[j+1] = held_words[j];
          j--;
        end
        held_words[j+1] = key;
      end
      for (int k = 0; k < held_count; k++) begin
        w = '{held_words[k], k == held_count - 1, held_lost};
        sorted_q.insert(sorted_q.size(), w);
      end
      held_count = 0;
      held_lost = 1'b0;
    end
  endtask

  task automatic send_word(input logic signed [DW-1:0] v, input logic l, input bit typed,
                           input logic signed [DW-1:0] ev);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= v;
    in_last    <= l;
    word_typed <= typed;
    word_exp   <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_sequence(input int len);
    logic signed [DW-1:0] v;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(3))
        0: v = $signed($urandom_range(0, 15)) - 32'sd8;
        1: begin
          case ($urandom_range(3))
            0: v = VMIN;
            1: v = VMAX;
            2: v = '0;
            default: v = -32'sd1;
          endcase
        end
        default: v = $urandom;
      endcase
      send_word(v, k == len - 1, 1'b0, '0);
      words_sent++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      absorb_word(in_value, in_last);
      if (in_last && word_typed) begin
        sorted_q[sorted_q.size() - 1] = '{word_exp, 1'b1, 1'b0};
      end
    end
  end

  always @(posedge clk) begin
    sorted_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected word, got value %0d final %0b overflow %0b",
                 $time, out_sorted_value, out_final_res, out_overflow);
        errors++;
      end else begin
        exp_w = sorted_q.pop_front();
        if (out_sorted_value !== exp_w.value) begin
          $display("%0t: sorted_value expected %0d got %0d", $time, exp_w.value,
                   out_sorted_value);
          errors++;
        end
        if (out_final_res !== exp_w.is_final) begin
          $display("%0t: final_res expected %0b got %0b", $time, exp_w.is_final,
                   out_final_res);
          errors++;
        end
        if (out_overflow !== exp_w.ovf) begin
          $display("%0t: overflow expected %0b got %0b", $time, exp_w.ovf, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_go && out_valid) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        hold_go = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  initial begin
    logic signed [DW-1:0] v;
    int seq_idx;
    int len;
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (seq_rows[r]) begin
      v = seq_rows[r].first;
      for (int k = 0; k < seq_rows[r].count; k++) begin
        send_word(v, k == seq_rows[r].count - 1, seq_rows[r].typed, seq_rows[r].exp_val);
        v = v + seq_rows[r].step;
      end
    end

    seq_idx = 0;
    while (words_sent < RAND_WORDS || seq_idx <= 6) begin
      calm = (seq_idx >= 1 && seq_idx < 5);
      pick = $urandom_range(99);
      if (pick < 60)      len = $urandom_range(1, 8);
      else if (pick < 85) len = $urandom_range(9, 32);
      else if (pick < 95) len = $urandom_range(33, DEPTH);
      else                len = $urandom_range(DEPTH + 1, DEPTH + 8);
      if (seq_idx == 6) begin
        hold_go = 1'b1;
        len = DEPTH;
      end
      send_sequence(len);
      seq_idx++;
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sorted_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sorted_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
